@@ design/spt_pkg.sv @@
// shared types, codes and defaults for the sparse row pattern table
package spt_pkg;

  // fixed field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned COL_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // one slot: valid flag over the column
  localparam int unsigned SLOT_W = COL_W + 1;

  // parameter defaults
  localparam int unsigned MAX_ROWS_DEF  = 256;
  localparam int unsigned MAX_SLOTS_DEF = 8;
  localparam int unsigned MAX_COLS_DEF  = 65536;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG      = 2'd3;

  // outcome of one row scan
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic                wr_en;
  } scan_res_t;

endpackage

@@ design/spt_ram.sv @@
// generic single write port ram with registered read
module spt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/spt_scan.sv @@
// row scan: compares the slots in use of a row word and builds the updated word
module spt_scan #(
  parameter int unsigned MAX_SLOTS = spt_pkg::MAX_SLOTS_DEF,
  parameter int unsigned SCNT_W = 4,
  localparam int unsigned ROWW_W = MAX_SLOTS * spt_pkg::SLOT_W,
  localparam int unsigned SIDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic [ROWW_W-1:0]             row_word,
  input  logic [spt_pkg::CMD_W-1:0]     cmd,
  input  logic [spt_pkg::COL_W-1:0]     col,
  input  logic [SCNT_W-1:0]             num_slots,
  input  logic                          in_range,
  output spt_pkg::scan_res_t            res,
  output logic [ROWW_W-1:0]             new_word
);

  logic [MAX_SLOTS-1:0] hit;
  logic [MAX_SLOTS-1:0] empty;
  logic [MAX_SLOTS-1:0] stop;
  logic                 stop_any;
  logic [SIDX_W-1:0]    stop_idx;
  logic                 hit_any;
  logic [SIDX_W-1:0]    hit_idx;

  // per slot compare, limited to the slots in use
  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      logic [spt_pkg::SLOT_W-1:0] s;
      s = row_word[k*spt_pkg::SLOT_W +: spt_pkg::SLOT_W];
      hit[k]   = (k < int'(num_slots)) && s[spt_pkg::COL_W] &&
                 (s[spt_pkg::COL_W-1:0] == col);
      empty[k] = (k < int'(num_slots)) && !s[spt_pkg::COL_W];
    end
    stop = hit | empty;
  end

  // lowest set slot wins
  always_comb begin
    stop_any = 1'b0;
    stop_idx = '0;
    hit_any  = 1'b0;
    hit_idx  = '0;
    for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
      if (stop[k]) begin
        stop_any = 1'b1;
        stop_idx = SIDX_W'(k);
      end
      if (hit[k]) begin
        hit_any = 1'b1;
        hit_idx = SIDX_W'(k);
      end
    end
  end

  // outcome and write-back word
  always_comb begin
    res.status   = spt_pkg::ST_RANGE;
    res.position = '0;
    res.wr_en    = 1'b0;
    new_word     = row_word;
    if (in_range && cmd == spt_pkg::CMD_ADD) begin
      if (!stop_any) begin
        res.status = spt_pkg::ST_FULL;
      end else if (hit[stop_idx]) begin
        res.status   = spt_pkg::ST_PRESENT;
        res.position = spt_pkg::POS_W'(32'(stop_idx));
      end else begin
        res.status   = spt_pkg::ST_INSERTED;
        res.position = spt_pkg::POS_W'(32'(stop_idx));
        res.wr_en    = 1'b1;
        for (int k = 0; k < MAX_SLOTS; k++) begin
          if (SIDX_W'(k) == stop_idx) begin
            new_word[k*spt_pkg::SLOT_W +: spt_pkg::SLOT_W] = {1'b1, col};
          end
        end
      end
    end else if (in_range && cmd == spt_pkg::CMD_FIND) begin
      if (hit_any) begin
        res.status   = spt_pkg::ST_FOUND;
        res.position = spt_pkg::POS_W'(32'(hit_idx));
      end else begin
        res.status = spt_pkg::ST_NOTFOUND;
      end
    end
  end

endmodule

@@ design/sparse_row_pattern_table.sv @@
// top level of the sparse row pattern table: control, configuration and row memory
//
//  channel  ports                                     word accepted when
//  -------  ----------------------------------------  ------------------------
//  input    in_cmd, in_row, in_col                    start && !busy
//  result   out_status, out_position                  out_valid (one cycle)
//  config   cfg_we, cfg_index, cfg_wdata              cfg_we
//
// add and find: one row read from the row memory, then the scan and write-back of the
// whole row word; the result strobes in the next cycle.
// clear sweeps the memory one row per cycle through all MAX_ROWS rows, then its result.
// after reset a like sweep, with no diagonal seed, runs with busy high and no result;
// configuration writes are taken throughout. the receiver cannot stall.
module sparse_row_pattern_table #(
  parameter int unsigned MAX_ROWS  = spt_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_SLOTS = spt_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MAX_COLS  = spt_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [spt_pkg::CMD_W-1:0]        in_cmd,
  input  logic [spt_pkg::ROW_W-1:0]        in_row,
  input  logic [spt_pkg::COL_W-1:0]        in_col,
  output logic                             out_valid,
  output logic [spt_pkg::STATUS_W-1:0]     out_status,
  output logic [spt_pkg::POS_W-1:0]        out_position,
  input  logic                             cfg_we,
  input  logic [spt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned RA_W   = $clog2(MAX_ROWS);
  localparam int unsigned ROWW_W = MAX_SLOTS * spt_pkg::SLOT_W;
  localparam int unsigned SCNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [8:0]  num_rows_r;
  logic [16:0] num_cols_r;
  logic [3:0]  slots_r;
  logic        diag_r;

  // latched item and sweep control
  logic [spt_pkg::CMD_W-1:0] cmd_r;
  logic [spt_pkg::ROW_W-1:0] row_r;
  logic [spt_pkg::COL_W-1:0] col_r;
  logic [RA_W-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic                      seed_r, seed_nxt;
  logic                      report_r, report_nxt;

  // result registers
  logic                          out_valid_r, out_valid_nxt;
  logic [spt_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [spt_pkg::POS_W-1:0]     out_position_r, out_position_nxt;

  // derived configuration
  logic              any_zero;
  logic              diag_mode;
  logic [3:0]        slots_clamp;
  logic [3:0]        slots_diag;
  logic [SCNT_W-1:0] num_slots;
  logic              in_range;

  // memory and scan signals
  logic              accept;
  logic              mem_we;
  logic [RA_W-1:0]   mem_waddr;
  logic [ROWW_W-1:0] mem_wdata;
  logic [ROWW_W-1:0] mem_rdata;
  logic [ROWW_W-1:0] seed_word;
  spt_pkg::scan_res_t scan_res;
  logic [ROWW_W-1:0] scan_word;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= '0;
      num_cols_r <= '0;
      slots_r    <= '0;
      diag_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spt_pkg::REG_NUM_ROWS: num_rows_r <= cfg_wdata[8:0];
        spt_pkg::REG_NUM_COLS: num_cols_r <= cfg_wdata;
        spt_pkg::REG_SLOTS:    slots_r    <= cfg_wdata[3:0];
        spt_pkg::REG_DIAG:     diag_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective sizes of the pattern
  always_comb begin
    any_zero    = (num_rows_r == '0) || (num_cols_r == '0);
    diag_mode   = diag_r && (17'(num_rows_r) == num_cols_r) && !any_zero;
    slots_clamp = (num_cols_r < 17'(slots_r)) ? num_cols_r[3:0] : slots_r;
    slots_diag  = (diag_mode && slots_clamp == '0) ? 4'd1 : slots_clamp;
    if (any_zero) begin
      num_slots = '0;
    end else if (32'(slots_diag) > MAX_SLOTS) begin
      num_slots = SCNT_W'(MAX_SLOTS);
    end else begin
      num_slots = SCNT_W'(slots_diag);
    end
    in_range = !any_zero &&
               (32'(row_r) < 32'(num_rows_r)) && (32'(row_r) < MAX_ROWS) &&
               (32'(col_r) < 32'(num_cols_r)) && (32'(col_r) < MAX_COLS);
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      row_r <= in_row;
      col_r <= in_col;
    end
  end

  // row memory, one whole row per word
  spt_ram #(
    .WIDTH (ROWW_W),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (RA_W'(in_row)),
    .rdata (mem_rdata)
  );

  // scan of the row just read
  spt_scan #(
    .MAX_SLOTS (MAX_SLOTS),
    .SCNT_W    (SCNT_W)
  ) u_scan (
    .row_word  (mem_rdata),
    .cmd       (cmd_r),
    .col       (col_r),
    .num_slots (num_slots),
    .in_range  (in_range),
    .res       (scan_res),
    .new_word  (scan_word)
  );

  // word written by the clearing sweep, diagonal seeded in slot zero
  always_comb begin
    seed_word = '0;
    if (seed_r && (32'(clr_cnt_r) < 32'(num_rows_r))) begin
      seed_word[spt_pkg::SLOT_W-1:0] = {1'b1, spt_pkg::COL_W'(clr_cnt_r)};
    end
  end

  // memory write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = RA_W'(row_r);
    mem_wdata = scan_word;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = seed_word;
    end else if (state_r == S_EVAL) begin
      mem_we = scan_res.wr_en;
    end
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    seed_nxt         = seed_r;
    report_nxt       = report_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == spt_pkg::CMD_CLEAR) begin
            state_nxt   = S_CLEAR;
            clr_cnt_nxt = '0;
            seed_nxt    = diag_mode;
            report_nxt  = 1'b1;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        state_nxt        = S_IDLE;
        out_valid_nxt    = 1'b1;
        out_status_nxt   = scan_res.status;
        out_position_nxt = scan_res.position;
      end
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + RA_W'(1);
        if (32'(clr_cnt_r) == MAX_ROWS - 1) begin
          state_nxt        = S_IDLE;
          out_valid_nxt    = report_r;
          out_status_nxt   = spt_pkg::ST_CLEARED;
          out_position_nxt = '0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers; reset starts a silent clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      seed_r      <= 1'b0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      seed_r      <= seed_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;

`ifndef SYNTHESIS
  // a result only follows a scan or the end of a reported sweep
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_EVAL) ||
                  ($past(state_r) == S_CLEAR && $past(report_r)))
    else $error("result strobe without a finished command");

  // the sweep writes a row in every cycle
  a_sweep_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> mem_we && (mem_waddr == clr_cnt_r))
    else $error("clearing sweep missed a row");

  // an accepted add or find is scanned in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd != spt_pkg::CMD_CLEAR) |=> (state_r == S_EVAL))
    else $error("accepted word not scanned");

  // no write to the memory outside a scan or a sweep
  a_write_guard: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EVAL) || (state_r == S_CLEAR))
    else $error("memory written while idle");
`endif

endmodule
